// ----- design/hmq_pkg.sv -----
// shared widths and codes for the heightmap height query block
`timescale 1ns / 1ps

package hmq_pkg;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_RESET = 64;

  // input item fields
  localparam int LOAD_INDEX_W = 12;
  localparam int COORD_W      = 18;
  localparam int COORD_MAG_W  = COORD_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } hmq_reg_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } hmq_cmd_e;

endpackage

// ----- design/hmq_if.sv -----
// item channels of the heightmap height query block
`timescale 1ns / 1ps

interface hmq_in_if import hmq_pkg::*; #(
  parameter int HEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [LOAD_INDEX_W-1:0]       load_index;
  logic signed [HEIGHT_BITS-1:0] load_value;
  logic signed [COORD_W-1:0]     query_u;
  logic signed [COORD_W-1:0]     query_v;

  modport source (
    output valid, cmd, load_index, load_value, query_u, query_v,
    input  ready
  );
  modport sink (
    input  valid, cmd, load_index, load_value, query_u, query_v,
    output ready
  );
endinterface

interface hmq_out_if import hmq_pkg::*; #(
  parameter int HEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_out;
  logic                          out_of_range;

  modport source (
    output valid, height_out, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, height_out, out_of_range,
    output ready
  );
endinterface

// ----- design/hmq_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hmq_ram import hmq_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/hmq_out_fifo.sv -----
// small result queue between the arithmetic pipeline and the output channel
`timescale 1ns / 1ps

module hmq_out_fifo import hmq_pkg::*; #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;

  // pointers wrap at the depth, which need not be a power of two
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/heightmap_triangle_height_query_top.sv -----
// top level of the heightmap triangle height query block
`timescale 1ns / 1ps

// Keeps a GRID_SIDE x GRID_SIDE grid of signed heights (row-major) and answers
// height queries by triangle interpolation inside one grid cell. A load item
// writes one sample and gives no result; a query item gives exactly one result.
// The block takes one item per clock when the result side keeps up, loads and
// queries mixed freely. Before a query's result is offered on the output, it
// passes these steps in order: scale by the grid size, split into cell and
// fraction plus the cell address, corner read from memory, interpolation
// products, final sum into the result queue. The four corners come from four
// copies of the height store, each read at one corner address per cycle; every
// load writes all four copies. Loads and corner reads both happen in the same
// pipeline stage, so a query always sees every load accepted before it with no
// forwarding. Input ready drops only when the 8-entry result queue could be
// filled by queries already in flight. Configuration (grid width, grid height;
// values above GRID_SIDE act as GRID_SIDE) must be written only while the block
// is idle; the block itself does not enforce this. Samples never written read
// as unknown data.
module heightmap_triangle_height_query_top import hmq_pkg::*; #(
  parameter int GRID_SIDE   = 64,
  parameter int HEIGHT_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  hmq_in_if.sink               item_i,
  hmq_out_if.source            result_o
);

  localparam int HB        = HEIGHT_BITS;
  localparam int FB        = FRAC_BITS;
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
  localparam int AW        = $clog2(DEPTH);
  localparam int IW        = $clog2(GRID_SIDE);
  localparam int EW        = $clog2(GRID_SIDE + 1);
  // scaled coordinate: integer part plus FB fraction bits
  localparam int XW        = (COORD_MAG_W + EW > FB) ? COORD_MAG_W + EW : FB + 1;
  localparam int BW        = IW + EW + 1;
  localparam int PW        = HB + FB + 3;
  localparam int ACW       = PW + 1;
  localparam int OUT_DEPTH = 8;
  localparam int CRW       = $clog2(OUT_DEPTH + 1);
  localparam int NCORNER   = 4;
  localparam int DIM_RESET = (CFG_RESET > GRID_SIDE) ? GRID_SIDE : CFG_RESET;

  // corner copies of the store
  localparam int C_BL = 0;
  localparam int C_BR = 1;
  localparam int C_TL = 2;
  localparam int C_TR = 3;

  localparam logic signed [ACW-1:0] H_MAX = {{(ACW-HB+1){1'b0}}, {(HB-1){1'b1}}};
  localparam logic signed [ACW-1:0] H_MIN = ~H_MAX;
  localparam logic [FB:0]           ONE   = {1'b1, {FB{1'b0}}};

  function automatic logic [EW-1:0] clamp_dim(input logic [CFG_W-1:0] val);
    if (32'(val) > GRID_SIDE) begin
      return EW'(GRID_SIDE);
    end
    return EW'(val);
  endfunction

  // configuration, stored already clamped to the grid side
  logic [EW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= EW'(DIM_RESET);
      height_q <= EW'(DIM_RESET);
    end else if (cfg_we_i) begin
      unique case (hmq_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  width_q  <= clamp_dim(cfg_data_i);
        REG_GRID_HEIGHT: height_q <= clamp_dim(cfg_data_i);
      endcase
    end
  end

  // input handshake and result credits
  logic           in_fire, query_fire, out_fire;
  logic [CRW-1:0] credit_q, credit_d;

  assign item_i.ready = (credit_q < CRW'(OUT_DEPTH));
  assign in_fire      = item_i.valid & item_i.ready;
  assign query_fire   = in_fire & (item_i.cmd == CMD_QUERY);
  assign out_fire     = result_o.valid & result_o.ready;
  assign credit_d     = credit_q + CRW'(query_fire) - CRW'(out_fire);

  // stage 1: scale by grid size
  logic                s1_valid_q;
  logic                s1_query_q, s1_neg_q;
  logic [XW-1:0]       s1_xs_q, s1_zs_q;
  logic [31:0]         lidx_ext;
  logic                s1_lidx_ok_q;
  logic [AW-1:0]       s1_waddr_q;
  logic [HB-1:0]       s1_wval_q;

  assign lidx_ext = 32'(item_i.load_index);

  // stage 2: cell, fraction, range check, cell address
  logic [XW-1:0]       ix, iz;
  logic [FB-1:0]       fx, fz;
  logic                oor_d;
  logic [BW-1:0]       base_full;
  logic                s2_valid_q, s2_query_q, s2_oor_q, s2_we_q;
  logic [FB-1:0]       s2_fx_q, s2_fz_q;
  logic [AW-1:0]       s2_base_q, s2_waddr_q;
  logic [HB-1:0]       s2_wval_q;
  logic [AW-1:0]       rd_addr [NCORNER];
  logic [HB-1:0]       rd_data [NCORNER];

  assign ix = s1_xs_q >> FB;
  assign iz = s1_zs_q >> FB;
  assign fx = s1_xs_q[FB-1:0];
  assign fz = s1_zs_q[FB-1:0];
  // cell at or past the last row or column, negative coordinate, or a grid too small for a cell
  assign oor_d = s1_neg_q
               | (({1'b0, ix} + (XW+1)'(1)) >= (XW+1)'(width_q))
               | (({1'b0, iz} + (XW+1)'(1)) >= (XW+1)'(height_q));
  assign base_full = BW'(iz[IW-1:0]) * BW'(width_q) + BW'(ix[IW-1:0]);

  assign rd_addr[C_BL] = s2_base_q;
  assign rd_addr[C_BR] = s2_base_q + AW'(1);
  assign rd_addr[C_TL] = s2_base_q + AW'(width_q);
  assign rd_addr[C_TR] = s2_base_q + AW'(width_q) + AW'(1);

  for (genvar c = 0; c < NCORNER; c++) begin : g_copy
    hmq_ram #(
      .WIDTH (HB),
      .DEPTH (DEPTH)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (s2_we_q),
      .waddr_i (s2_waddr_q),
      .wdata_i (s2_wval_q),
      .raddr_i (rd_addr[c]),
      .rdata_o (rd_data[c])
    );
  end

  // stage 3: triangle select and interpolation products
  logic                 s3_valid_q, s3_oor_q;
  logic [FB-1:0]        s3_fx_q, s3_fz_q;
  logic signed [HB-1:0] bl, br, tl, tr;
  logic [FB:0]          fsum;
  logic                 lower;
  logic [FB:0]          m1, m2;
  logic signed [HB:0]   d1, d2;
  logic signed [HB-1:0] anchor;
  logic signed [PW-1:0] p1_d, p2_d;

  assign bl   = $signed(rd_data[C_BL]);
  assign br   = $signed(rd_data[C_BR]);
  assign tl   = $signed(rd_data[C_TL]);
  assign tr   = $signed(rd_data[C_TR]);
  assign fsum = {1'b0, s3_fx_q} + {1'b0, s3_fz_q};
  assign lower = ~fsum[FB];

  always_comb begin
    if (lower) begin
      anchor = bl;
      d1     = (HB+1)'(br) - (HB+1)'(bl);
      d2     = (HB+1)'(tl) - (HB+1)'(bl);
      m1     = {1'b0, s3_fx_q};
      m2     = {1'b0, s3_fz_q};
    end else begin
      anchor = tr;
      d1     = (HB+1)'(tl) - (HB+1)'(tr);
      d2     = (HB+1)'(br) - (HB+1)'(tr);
      m1     = ONE - {1'b0, s3_fx_q};
      m2     = ONE - {1'b0, s3_fz_q};
    end
  end

  assign p1_d = PW'(d1) * PW'($signed({1'b0, m1}));
  assign p2_d = PW'(d2) * PW'($signed({1'b0, m2}));

  // stage 4: sum, floor to height format, saturate
  logic                  s4_valid_q, s4_oor_q;
  logic signed [HB-1:0]  s4_anchor_q;
  logic signed [PW-1:0]  s4_p1_q, s4_p2_q;
  logic signed [ACW-1:0] acc, res_full, res_sat;
  logic [HB-1:0]         height_d;

  assign acc      = (ACW'(s4_anchor_q) <<< FB) + ACW'(s4_p1_q) + ACW'(s4_p2_q);
  assign res_full = acc >>> FB;

  always_comb begin
    res_sat = res_full;
    if (res_full > H_MAX) begin
      res_sat = H_MAX;
    end else if (res_full < H_MIN) begin
      res_sat = H_MIN;
    end
    height_d = s4_oor_q ? '0 : res_sat[HB-1:0];
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_we_q    <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      credit_q   <= credit_d;
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
      s2_we_q    <= s1_valid_q & ~s1_query_q & s1_lidx_ok_q;
      // from stage 3 on only queries travel
      s3_valid_q <= s2_valid_q & s2_query_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_query_q   <= (item_i.cmd == CMD_QUERY);
    s1_neg_q     <= item_i.query_u[COORD_W-1] | item_i.query_v[COORD_W-1];
    s1_xs_q      <= XW'(item_i.query_u[COORD_MAG_W-1:0]) * XW'(width_q);
    s1_zs_q      <= XW'(item_i.query_v[COORD_MAG_W-1:0]) * XW'(height_q);
    s1_lidx_ok_q <= (lidx_ext < DEPTH);
    s1_waddr_q   <= lidx_ext[AW-1:0];
    s1_wval_q    <= item_i.load_value;

    s2_query_q   <= s1_query_q;
    s2_oor_q     <= oor_d;
    s2_fx_q      <= fx;
    s2_fz_q      <= fz;
    s2_base_q    <= base_full[AW-1:0];
    s2_waddr_q   <= s1_waddr_q;
    s2_wval_q    <= s1_wval_q;

    s3_oor_q     <= s2_oor_q;
    s3_fx_q      <= s2_fx_q;
    s3_fz_q      <= s2_fz_q;

    s4_oor_q     <= s3_oor_q;
    s4_anchor_q  <= anchor;
    s4_p1_q      <= p1_d;
    s4_p2_q      <= p2_d;
  end

  // result queue, never overfilled thanks to the credit count
  logic [HB:0] fifo_out;

  hmq_out_fifo #(
    .WIDTH (HB + 1),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s4_valid_q),
    .data_i  ({s4_oor_q, height_d}),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (fifo_out)
  );

  assign result_o.height_out   = $signed(fifo_out[HB-1:0]);
  assign result_o.out_of_range = fifo_out[HB];

endmodule
